// ----- rtl/gbn_pkg.sv -----
// Shared types and constants for the go-back-N sender window unit.
package gbn_pkg;

  localparam int unsigned MAX_WINDOW = 7;
  localparam int unsigned REP_W      = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SEQ_W      = 8;
  localparam int unsigned WIN_W      = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [WIN_W-1:0] WINDOW_SIZE_RST  = 3'd7;
  localparam logic [SEQ_W-1:0] PACKET_COUNT_RST = 8'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_COUNT = 1'b1;

  typedef enum logic [1:0] {
    MODE_SEND    = 2'd0,
    MODE_ACK     = 2'd1,
    MODE_TIMEOUT = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_REPLAY = 1'b1
  } state_e;

  typedef struct packed {
    logic accept;
    logic replay_step;
  } gbn_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic replay_multi;
    logic replay_final;
  } gbn_sts_t;

endpackage

// ----- rtl/gbn_in_if.sv -----
// Request channel carrying one sender event.
interface gbn_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] ack_seq;

  modport source (output valid, output mode, output ack_seq, input ready);
  modport sink   (input valid, input mode, input ack_seq, output ready);
endinterface

// ----- rtl/gbn_out_if.sv -----
// Result channel carrying one send or status result.
interface gbn_out_if;
  logic       valid;
  logic       ready;
  logic       send_valid;
  logic [7:0] packet_index;
  logic       is_retransmit;
  logic       ack_accepted;
  logic       finished;
  logic       last;

  modport source (output valid, output send_valid, output packet_index,
                  output is_retransmit, output ack_accepted, output finished,
                  output last, input ready);
  modport sink   (input valid, input send_valid, input packet_index,
                  input is_retransmit, input ack_accepted, input finished,
                  input last, output ready);
endinterface

// ----- rtl/go_back_n_sender_window_unit.sv -----
// Go-back-N sender window unit: top level joining controller and datapath.
// The first result of a request is registered and shown in the cycle after it is accepted.
// Results: send, acknowledgement and unused requests give a single result each; a timeout gives
// one result per replayed index (0 to 7 indices; a single result if none), and no request is accepted while it replays.
// Reset: asynchronous, active low; clears the window, sets window_size 7, packet_count 1.
module go_back_n_sender_window_unit
  import gbn_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  gbn_in_if.sink                in_if,
  gbn_out_if.source             out_if
);

  gbn_cmd_t cmd;
  gbn_sts_t sts;
  mode_e    mode;

  assign mode = mode_e'(in_if.mode);

  gbn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .mode_i     (mode),
    .sts_i      (sts),
    .in_ready_o (in_if.ready),
    .cmd_o      (cmd)
  );

  gbn_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .mode_i     (mode),
    .ack_seq_i  (in_if.ack_seq),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_if     (out_if)
  );

  a_accept_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> out_if.valid)
    else $error("accepted request gave no result");

  a_no_accept_in_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.replay_step |-> !in_if.ready)
    else $error("request accepted during replay");

  a_non_last_is_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.last |-> out_if.is_retransmit && out_if.send_valid)
    else $error("non-final result outside a replay");

  a_retx_no_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.is_retransmit |-> !out_if.ack_accepted)
    else $error("replay result marked as accepted ack");

endmodule

// ----- rtl/gbn_ctrl.sv -----
// Controller state machine: event accept and timeout replay sequencing.
module gbn_ctrl
  import gbn_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  mode_e    mode_i,
  input  gbn_sts_t sts_i,
  output logic     in_ready_o,
  output gbn_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.slot_free && mode_i == MODE_TIMEOUT && sts_i.replay_multi) begin
          state_d = ST_REPLAY;
        end
      end
      ST_REPLAY: begin
        if (sts_i.slot_free && sts_i.replay_final) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o.accept      = 1'b0;
    cmd_o.replay_step = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = sts_i.slot_free;
        cmd_o.accept = in_valid_i && sts_i.slot_free;
      end
      ST_REPLAY: begin
        cmd_o.replay_step = sts_i.slot_free;
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/gbn_datapath.sv -----
// Datapath: window state, configuration registers and result register.
module gbn_datapath
  import gbn_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  mode_e                 mode_i,
  input  logic [SEQ_W-1:0]      ack_seq_i,
  input  gbn_cmd_t              cmd_i,
  output gbn_sts_t              sts_o,
  gbn_out_if.source             out_if
);

  logic [WIN_W-1:0] window_size_q;
  logic [SEQ_W-1:0] packet_count_q;
  logic [SEQ_W-1:0] base_q, base_d;
  logic [SEQ_W-1:0] next_q, next_d;
  logic             done_q, done_d;
  logic [REP_W-1:0] rep_idx_q, rep_idx_d;
  logic [REP_W-1:0] rep_cnt_q, rep_cnt_d;
  logic             out_valid_q, out_valid_d;

  logic             send_valid_q, send_valid_d;
  logic [SEQ_W-1:0] index_q, index_d;
  logic             retx_q, retx_d;
  logic             acc_q, acc_d;
  logic             fin_q, fin_d;
  logic             last_q, last_d;

  logic [SEQ_W-1:0] outstanding;
  logic [SEQ_W-1:0] eff_window;
  logic [REP_W-1:0] rep_cnt_new;
  logic [REP_W:0]   rep_idx_inc;
  logic             can_send;
  logic             ack_hit;

  assign outstanding = (next_q >= base_q) ? (next_q - base_q) : '0;
  assign eff_window  = ({5'd0, window_size_q} > SEQ_W'(MAX_WINDOW)) ? SEQ_W'(MAX_WINDOW)
                                                                     : {5'd0, window_size_q};
  assign rep_cnt_new = (outstanding > SEQ_W'(MAX_WINDOW)) ? REP_W'(MAX_WINDOW)
                                                          : outstanding[REP_W-1:0];
  assign rep_idx_inc = {1'b0, rep_idx_q} + (REP_W+1)'(1);
  assign can_send    = (outstanding < eff_window) && (next_q < packet_count_q);
  assign ack_hit     = (outstanding != '0) && (ack_seq_i == base_q);

  assign sts_o.slot_free    = !out_valid_q || out_if.ready;
  assign sts_o.replay_multi = rep_cnt_new > REP_W'(1);
  assign sts_o.replay_final = rep_idx_inc == {1'b0, rep_cnt_q};

  always_comb begin
    base_d       = base_q;
    next_d       = next_q;
    done_d       = done_q;
    rep_idx_d    = rep_idx_q;
    rep_cnt_d    = rep_cnt_q;
    out_valid_d  = out_valid_q && !out_if.ready;
    send_valid_d = send_valid_q;
    index_d      = index_q;
    retx_d       = retx_q;
    acc_d        = acc_q;
    fin_d        = fin_q;
    last_d       = last_q;
    if (cmd_i.accept) begin
      out_valid_d  = 1'b1;
      send_valid_d = 1'b0;
      index_d      = '0;
      retx_d       = 1'b0;
      acc_d        = 1'b0;
      fin_d        = done_q;
      last_d       = 1'b1;
      case (mode_i)
        MODE_SEND: begin
          if (can_send) begin
            send_valid_d = 1'b1;
            index_d      = next_q;
            next_d       = next_q + SEQ_W'(1);
          end
        end
        MODE_ACK: begin
          if (ack_hit) begin
            acc_d  = 1'b1;
            base_d = base_q + SEQ_W'(1);
            if (packet_count_q != '0 && base_q == packet_count_q - SEQ_W'(1)) begin
              done_d = 1'b1;
              fin_d  = 1'b1;
            end
          end
        end
        MODE_TIMEOUT: begin
          if (rep_cnt_new != '0) begin
            send_valid_d = 1'b1;
            index_d      = base_q;
            retx_d       = 1'b1;
            last_d       = rep_cnt_new == REP_W'(1);
            rep_idx_d    = REP_W'(1);
            rep_cnt_d    = rep_cnt_new;
          end
        end
        default: last_d = 1'b1;
      endcase
    end else if (cmd_i.replay_step) begin
      out_valid_d  = 1'b1;
      send_valid_d = 1'b1;
      index_d      = base_q + {{(SEQ_W-REP_W){1'b0}}, rep_idx_q};
      retx_d       = 1'b1;
      acc_d        = 1'b0;
      fin_d        = done_q;
      last_d       = sts_o.replay_final;
      rep_idx_d    = rep_idx_inc[REP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q  <= WINDOW_SIZE_RST;
      packet_count_q <= PACKET_COUNT_RST;
      base_q         <= '0;
      next_q         <= '0;
      done_q         <= 1'b0;
      rep_idx_q      <= '0;
      rep_cnt_q      <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WINDOW_SIZE:  window_size_q  <= cfg_data_i[WIN_W-1:0];
          CFG_PACKET_COUNT: packet_count_q <= cfg_data_i[SEQ_W-1:0];
          default:          window_size_q  <= window_size_q;
        endcase
      end
      base_q      <= base_d;
      next_q      <= next_d;
      done_q      <= done_d;
      rep_idx_q   <= rep_idx_d;
      rep_cnt_q   <= rep_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    send_valid_q <= send_valid_d;
    index_q      <= index_d;
    retx_q       <= retx_d;
    acc_q        <= acc_d;
    fin_q        <= fin_d;
    last_q       <= last_d;
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.send_valid    = send_valid_q;
  assign out_if.packet_index  = index_q;
  assign out_if.is_retransmit = retx_q;
  assign out_if.ack_accepted  = acc_q;
  assign out_if.finished      = fin_q;
  assign out_if.last          = last_q;

endmodule
